// ----- rtl/core/fro_pkg.sv -----
package fro_pkg;

   // Geometry and sizing
   localparam int MAX_DIGITS = 8;
   localparam int COORD_BITS = 12;
   localparam int IDX_BITS = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int COLOR_BITS = 16;
   localparam int ZOOM_BITS = 8;
   localparam int INTERVAL_BITS = 16;
   localparam int TIME_BITS = 32;
   localparam int RATE_BITS = 27;
   localparam int COUNT_BITS = 4;

   // Rate computation
   localparam logic [RATE_BITS-1:0] RATE_MAX = 27'd99999999;
   localparam int SCALE_BITS = 10;
   localparam logic [SCALE_BITS-1:0] RATE_SCALE = 10'd1000;
   localparam int NUM_BITS = RATE_BITS + SCALE_BITS;
   localparam int BCD_DIGITS = 8;
   localparam int DIV_STEPS = NUM_BITS;
   localparam int BCD_STEPS = RATE_BITS;
   localparam int STEP_BITS = 6;

   // Configuration port
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TEXT_X = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TEXT_Y = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ZOOM = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INTERVAL = 8'd3;

   localparam logic [COORD_BITS-1:0] TEXT_X_RESET = 12'd4;
   localparam logic [COORD_BITS-1:0] TEXT_Y_RESET = 12'd0;
   localparam logic [ZOOM_BITS-1:0] ZOOM_RESET = 8'd2;
   localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = 16'd1000;

   // Item kinds
   localparam logic ITEM_FRAME = 1'b0;
   localparam logic ITEM_PIXEL = 1'b1;

   localparam logic [COLOR_BITS-1:0] PIXEL_INVERT = 16'hFFFF;

   // 5 rows of 40 bits, digit n at columns 4n..4n+3, first column at the MSB
   localparam int FONT_BITS = 200;
   localparam logic [FONT_BITS-1:0] FONT_ROM =
      200'hE2EEAEEEEE_A222A882AA_A2E6EEE2EE_A28222A2A2_E2EE2EE2EE;
   localparam logic [7:0] FONT_LAST = 8'd199;
   localparam logic [7:0] FONT_ROW_STRIDE = 8'd40;

   typedef struct packed {
      logic                  req_type;
      logic [TIME_BITS-1:0]  time_ms;
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic [COLOR_BITS-1:0] pixel_in;
   } req_word_type;

   typedef struct packed {
      logic [COLOR_BITS-1:0] pixel_out;
      logic [RATE_BITS-1:0]  rate_shown;
   } rsp_word_type;

   typedef struct packed {
      logic accept;
      logic mul;
      logic div_step;
      logic sat;
      logic bcd_step;
      logic count;
   } fro_cmd_type;

   typedef struct packed {
      logic frame_item;
      logic window_hit;
      logic out_free;
   } fro_sts_type;

   function automatic logic glyph_lit(input logic [3:0] digit, input logic [1:0] col,
                                      input logic [2:0] row);
      logic [7:0] bit_pos;
      bit_pos = 8'(row) * FONT_ROW_STRIDE + {2'b00, digit, 2'b00} + {6'b0, col};
      if (digit > 4'd9 || row > 3'd4) begin
         return 1'b0;
      end
      return FONT_ROM[FONT_LAST - bit_pos];
   endfunction

   // v / z for z in 1..4 and v below 5*z; divide by three is (v*11)>>5
   function automatic logic [2:0] div_by_zoom(input logic [4:0] v, input logic [2:0] z);
      logic [8:0] prod;
      prod = {4'b0, v} * 9'd11;
      case (z)
         3'd1:    return v[2:0];
         3'd2:    return v[3:1];
         3'd3:    return prod[7:5];
         default: return v[4:2];
      endcase
   endfunction

endpackage

// ----- rtl/core/frame_rate_digit_overlay_core.sv -----
// Pixel words: result in the output register in the cycle after accept, one pixel per cycle
// while the output is free and no rate update runs. Frame words give no result. One that
// closes the rate window holds the input stalled after accept through multiply, divide one
// quotient bit a cycle, clamp, binary to BCD one bit a cycle, digit count; others don't stall.
// Synchronous reset restores register defaults, clears counts and time, and shows rate 0.
module frame_rate_digit_overlay_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  fro_pkg::req_word_type              req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output fro_pkg::rsp_word_type              rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fro_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [fro_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import fro_pkg::*;

   fro_cmd_type cmd;
   fro_sts_type sts;

   fro_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fro_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// ----- rtl/core/fro_ctrl.sv -----
module fro_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  fro_pkg::fro_sts_type sts,
   output fro_pkg::fro_cmd_type cmd
);
   import fro_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_SAT,
      ST_BCD,
      ST_COUNT
   } state_type;

   state_type             state_ff, state_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  idle;

   assign idle = (state_ff == ST_IDLE);
   assign req_stall = !(idle && sts.out_free);

   always_comb begin
      cmd = '0;
      cmd.accept = idle && sts.out_free && req_valid;
      cmd.mul = (state_ff == ST_MUL);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.sat = (state_ff == ST_SAT);
      cmd.bcd_step = (state_ff == ST_BCD);
      cmd.count = (state_ff == ST_COUNT);
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && sts.frame_item && sts.window_hit) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_DIV;
            step_in = '0;
         end
         ST_DIV: begin
            if (step_ff == STEP_BITS'(DIV_STEPS - 1)) begin
               state_in = ST_SAT;
               step_in = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_SAT: begin
            state_in = ST_BCD;
            step_in = '0;
         end
         ST_BCD: begin
            if (step_ff == STEP_BITS'(BCD_STEPS - 1)) begin
               state_in = ST_COUNT;
               step_in = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_COUNT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end

endmodule

// ----- rtl/core/fro_dp.sv -----
module fro_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fro_pkg::req_word_type                req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output fro_pkg::rsp_word_type                rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fro_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [fro_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  fro_pkg::fro_cmd_type                 cmd,
   output fro_pkg::fro_sts_type                 sts
);
   import fro_pkg::*;

   // configuration
   logic [COORD_BITS-1:0]    text_x_ff, text_x_in;
   logic [COORD_BITS-1:0]    text_y_ff, text_y_in;
   logic [ZOOM_BITS-1:0]     zoom_ff, zoom_in;
   logic [INTERVAL_BITS-1:0] interval_ff, interval_in;

   // rate state
   logic [RATE_BITS-1:0]     frame_count_ff, frame_count_in;
   logic [TIME_BITS-1:0]     window_start_ff, window_start_in;
   logic [RATE_BITS-1:0]     shown_rate_ff, shown_rate_in;
   logic [BCD_DIGITS-1:0][3:0] bcd_ff, bcd_in;
   logic [COUNT_BITS-1:0]    digits_ff, digits_in;

   // divide / convert working registers
   logic [RATE_BITS-1:0]     op_ff, op_in;
   logic [TIME_BITS-1:0]     divisor_ff, divisor_in;
   logic [NUM_BITS-1:0]      work_ff, work_in;
   logic [TIME_BITS-1:0]     rem_ff, rem_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_word_type             rsp_data_ff, rsp_data_in;

   logic                     frame_accept, pixel_accept;
   logic [TIME_BITS-1:0]     elapsed;
   logic [INTERVAL_BITS-1:0] need;
   logic                     window_hit;
   logic [RATE_BITS-1:0]     count_inc;

   logic [TIME_BITS:0]       trial;
   logic                     trial_ge;
   logic [TIME_BITS:0]       trial_diff;
   logic [RATE_BITS-1:0]     quotient_sat;
   logic [BCD_DIGITS*4-1:0]  bcd_adj;
   logic [COUNT_BITS-1:0]    digit_count;

   logic [COLOR_BITS-1:0]    pixel_res;

   assign frame_accept = cmd.accept && (req_data.req_type == ITEM_FRAME);
   assign pixel_accept = cmd.accept && (req_data.req_type == ITEM_PIXEL);

   // ---- frame window ----
   assign elapsed = req_data.time_ms - window_start_ff;
   assign need = (interval_ff == '0) ? INTERVAL_BITS'(1) : interval_ff;
   assign window_hit = elapsed >= {{(TIME_BITS-INTERVAL_BITS){1'b0}}, need};
   assign count_inc = (frame_count_ff < RATE_MAX) ? frame_count_ff + 1'b1 : frame_count_ff;

   assign sts.frame_item = (req_data.req_type == ITEM_FRAME);
   assign sts.window_hit = window_hit;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   // ---- restoring divide, one quotient bit per step ----
   assign trial = {rem_ff, work_ff[NUM_BITS-1]};
   assign trial_ge = trial >= {1'b0, divisor_ff};
   assign trial_diff = trial - {1'b0, divisor_ff};
   assign quotient_sat = (work_ff > NUM_BITS'(RATE_MAX)) ? RATE_MAX : work_ff[RATE_BITS-1:0];

   // ---- binary to BCD, add-3 then shift ----
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         bcd_adj[i*4 +: 4] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end

   always_comb begin
      digit_count = COUNT_BITS'(1);
      for (int i = 1; i < BCD_DIGITS; i++) begin
         if (bcd_ff[i] != 4'd0) begin
            digit_count = COUNT_BITS'(i + 1);
         end
      end
   end

   // ---- pixel overlay ----
   always_comb begin
      logic [2:0]             z;
      logic [4:0]             cellw;
      logic [4:0]             five_z;
      logic [COORD_BITS-1:0]  dx, dy;
      logic [COORD_BITS-1:0]  span;
      logic [COORD_BITS-1:0]  base;
      logic [COORD_BITS-1:0]  step_base;
      logic [COORD_BITS-1:0]  rem_x;
      logic [IDX_BITS-1:0]    idx;
      logic [COUNT_BITS-1:0]  pos;
      logic [3:0]             digit;
      logic [2:0]             col, row;
      logic                   hit;

      if (zoom_ff == '0) begin
         z = 3'd1;
      end else if (zoom_ff > ZOOM_BITS'(4)) begin
         z = 3'd4;
      end else begin
         z = zoom_ff[2:0];
      end
      cellw = {z, 2'b00};
      five_z = {z, 2'b00} + {2'b00, z};
      dx = req_data.pixel_x - text_x_ff;
      dy = req_data.pixel_y - text_y_ff;
      span = COORD_BITS'(MAX_DIGITS) * COORD_BITS'(cellw);

      // digit index by threshold compare, each digit cell is cellw wide
      idx = '0;
      base = '0;
      for (int k = 1; k < MAX_DIGITS; k++) begin
         step_base = COORD_BITS'(k) * COORD_BITS'(cellw);
         if (dx >= step_base) begin
            idx = IDX_BITS'(k);
            base = step_base;
         end
      end
      rem_x = dx - base;
      col = div_by_zoom(rem_x[4:0], z);
      row = div_by_zoom(dy[4:0], z);

      // digits are held least significant first; idx 0 is the leading digit
      pos = digits_ff - COUNT_BITS'(1) - COUNT_BITS'(idx);
      digit = bcd_ff[pos[2:0]];

      hit = (req_data.pixel_x >= text_x_ff) && (req_data.pixel_y >= text_y_ff)
            && (dy < COORD_BITS'(five_z)) && (dx < span)
            && (COUNT_BITS'(idx) < digits_ff)
            && glyph_lit(digit, col[1:0], row);
      pixel_res = hit ? (req_data.pixel_in ^ PIXEL_INVERT) : req_data.pixel_in;
   end

   // ---- next-state ----
   always_comb begin
      text_x_in = text_x_ff;
      text_y_in = text_y_ff;
      zoom_in = zoom_ff;
      interval_in = interval_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TEXT_X:   text_x_in = csr_data[COORD_BITS-1:0];
            CSR_TEXT_Y:   text_y_in = csr_data[COORD_BITS-1:0];
            CSR_ZOOM:     zoom_in = csr_data[ZOOM_BITS-1:0];
            CSR_INTERVAL: interval_in = csr_data[INTERVAL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      frame_count_in = frame_count_ff;
      window_start_in = window_start_ff;
      shown_rate_in = shown_rate_ff;
      bcd_in = bcd_ff;
      digits_in = digits_ff;
      op_in = op_ff;
      divisor_in = divisor_ff;
      work_in = work_ff;
      rem_in = rem_ff;

      if (frame_accept) begin
         if (window_hit) begin
            op_in = count_inc;
            divisor_in = elapsed;
            window_start_in = req_data.time_ms;
            frame_count_in = '0;
         end else begin
            frame_count_in = count_inc;
         end
      end
      if (cmd.mul) begin
         work_in = {{SCALE_BITS{1'b0}}, op_ff} * {{RATE_BITS{1'b0}}, RATE_SCALE};
         rem_in = '0;
      end
      if (cmd.div_step) begin
         rem_in = trial_ge ? trial_diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
         work_in = {work_ff[NUM_BITS-2:0], trial_ge};
      end
      if (cmd.sat) begin
         shown_rate_in = quotient_sat;
         work_in = {quotient_sat, {SCALE_BITS{1'b0}}};
         bcd_in = '0;
      end
      if (cmd.bcd_step) begin
         bcd_in = {bcd_adj[BCD_DIGITS*4-2:0], work_ff[NUM_BITS-1]};
         work_in = {work_ff[NUM_BITS-2:0], 1'b0};
      end
      if (cmd.count) begin
         digits_in = digit_count;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (pixel_accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.pixel_out = pixel_res;
         rsp_data_in.rate_shown = shown_rate_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_x_ff <= TEXT_X_RESET;
         text_y_ff <= TEXT_Y_RESET;
         zoom_ff <= ZOOM_RESET;
         interval_ff <= INTERVAL_RESET;
         frame_count_ff <= '0;
         window_start_ff <= '0;
         shown_rate_ff <= '0;
         bcd_ff <= '0;
         digits_ff <= COUNT_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         text_x_ff <= text_x_in;
         text_y_ff <= text_y_in;
         zoom_ff <= zoom_in;
         interval_ff <= interval_in;
         frame_count_ff <= frame_count_in;
         window_start_ff <= window_start_in;
         shown_rate_ff <= shown_rate_in;
         bcd_ff <= bcd_in;
         digits_ff <= digits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      divisor_ff <= divisor_in;
      work_ff <= work_in;
      rem_ff <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule
